/* rtl/bme_pkg.sv */
package bme_pkg;

    // Bound codes
    localparam logic signed [31:0] INFINITY   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_FINITE = 32'sh7FFF_FFFE;

    // Configuration register indexes
    localparam logic CFG_BINARY_MODE = 1'b0;
    localparam logic CFG_EPSILON     = 1'b1;

    // Item actions
    localparam logic ACT_SCAN  = 1'b0;
    localparam logic ACT_APPLY = 1'b1;

    // Apply item held between the product stage and the add stage
    typedef struct packed {
        logic signed [31:0] reference_bound;
        logic signed [31:0] own_bound;
        logic        [30:0] delta;
        logic               delta_sat;
    } bme_item_t;

    // Enlarged bound leaving the add stage
    typedef struct packed {
        logic signed [31:0] result_bound;
        logic               saturated;
    } bme_result_t;

endpackage

/* rtl/bound_matrix_epsilon_enlarge.sv */
// An accepted apply transaction passes the stage 1, stage 2 and result registers to the output.
// Throughput: one transaction per cycle while out_stall is low; scan transactions give no
// result and leave the pipe after the first stage, where the running maximum is updated.
// The delta product is registered ahead of the add stage.
// Reset: asynchronous, active low; clears the maximum, both configuration registers
// and all valid flags.
module bound_matrix_epsilon_enlarge
    import bme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [23:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic               first_of_pass,
    input  logic signed [31:0] reference_bound,
    input  logic signed [31:0] own_bound,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_bound,
    output logic               saturated
);

    logic               binary_mode_reg;
    logic        [23:0] epsilon_reg;
    logic        [30:0] max_abs_reg;
    logic        [30:0] max_abs_next;

    logic               valid1_reg;
    logic               action1_reg;
    logic               first1_reg;
    logic signed [31:0] ref1_reg;
    logic signed [31:0] own1_reg;

    logic               valid2_reg;
    bme_item_t          item2_reg;
    bme_item_t          item2_next;

    logic               out_valid_reg;
    bme_result_t        result_reg;
    bme_result_t        result_next;

    logic               adv_out;
    logic               adv2;
    logic               adv1;
    logic        [31:0] mag;
    logic        [30:0] mag_clip;
    logic        [30:0] max_base;
    logic        [54:0] prod;

    // Stage handshake: each stage moves when the one after it is free
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv2     = !valid2_reg || adv_out;
    assign adv1     = !valid1_reg || (action1_reg == ACT_SCAN) || adv2;
    assign in_stall = !adv1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
            epsilon_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BINARY_MODE: binary_mode_reg <= cfg_data[0];
                CFG_EPSILON:     epsilon_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Stage 1: hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else if (adv1)
            valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            action1_reg <= action;
            first1_reg  <= first_of_pass;
            ref1_reg    <= reference_bound;
            own1_reg    <= own_bound;
        end
    end

    // Running maximum of magnitude; the first scan of a pass starts from zero
    always_comb
    begin
        mag          = ref1_reg[31] ? 32'(-ref1_reg) : ref1_reg;
        mag_clip     = mag[31] ? 31'h7FFF_FFFF : mag[30:0];
        max_base     = first1_reg ? 31'd0 : max_abs_reg;
        max_abs_next = max_abs_reg;
        if (valid1_reg && (action1_reg == ACT_SCAN))
        begin
            if (ref1_reg == INFINITY)
                max_abs_next = max_base;
            else
                max_abs_next = (mag_clip > max_base) ? mag_clip : max_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_abs_reg <= '0;
        else
            max_abs_reg <= max_abs_next;
    end

    // Delta product from the maximum left by all earlier scans
    always_comb
    begin
        prod                       = 55'(max_abs_reg) * 55'(epsilon_reg);
        item2_next.reference_bound = ref1_reg;
        item2_next.own_bound       = own1_reg;
        item2_next.delta_sat       = |prod[54:47];
        item2_next.delta           = item2_next.delta_sat ? 31'h7FFF_FFFF : prod[46:16];
    end

    // Stage 2: hold apply transactions only, drop scans
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else if (adv2)
            valid2_reg <= valid1_reg && (action1_reg == ACT_APPLY);
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && valid1_reg && (action1_reg == ACT_APPLY))
            item2_reg <= item2_next;
    end

    // Add and clip
    bme_enlarge u_enlarge
    (
        .binary_mode (binary_mode_reg),
        .item        (item2_reg),
        .result      (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_out)
            out_valid_reg <= valid2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && valid2_reg)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_bound = result_reg.result_bound;
    assign saturated    = result_reg.saturated;

endmodule

/* rtl/bme_enlarge.sv */
module bme_enlarge
    import bme_pkg::*;
(
    input  logic        binary_mode,
    input  bme_item_t   item,
    output bme_result_t result
);

    logic               use_delta;
    logic signed [32:0] sum;

    // Pick between the delta path and the unchanged own bound
    assign use_delta = !binary_mode || (item.own_bound < item.reference_bound);
    assign sum = 33'(item.reference_bound) + $signed({2'b00, item.delta});

    // Infinity stays infinite; clip sums above the largest finite code
    always_comb
    begin
        priority if (!use_delta)
        begin
            result.result_bound = item.own_bound;
            result.saturated    = 1'b0;
        end
        else if (item.reference_bound == INFINITY)
        begin
            result.result_bound = INFINITY;
            result.saturated    = 1'b0;
        end
        else if (sum > 33'(MAX_FINITE))
        begin
            result.result_bound = MAX_FINITE;
            result.saturated    = 1'b1;
        end
        else
        begin
            result.result_bound = sum[31:0];
            result.saturated    = item.delta_sat;
        end
    end

endmodule
